// ----- sv/miwf_pkg.sv -----
// Package for the mesh interior wire filter.
// Holds widths, function and kind codes, FSM states and the control structs.
// Used by the interfaces, the controller, the datapath and the top level.
package miwf_pkg;

    localparam int unsigned VTX_W            = 16;
    localparam int unsigned MAX_VERTICES_DEF = 65536;
    localparam int unsigned N_SLOTS          = 5;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_TRI  = 2'd1;
    localparam logic [1:0] FUNC_QUAD = 2'd2;
    localparam logic [1:0] KIND_LINE = 2'd0;

    localparam logic [2:0] SLOT_FACE = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_FLUSH,
        S_PREP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       wr_en;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       emit_en;
        logic [2:0] emit_sel;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         func;
        logic               present;
        logic [N_SLOTS-1:0] mask;
        logic               out_free;
    } t_status;

endpackage

// ----- sv/miwf_ifs.sv -----
// Request and result channel interfaces of the mesh interior wire filter.
// Depends on miwf_pkg for the vertex index width.
interface miwf_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic [miwf_pkg::VTX_W-1:0] in_v0;
    logic [miwf_pkg::VTX_W-1:0] in_v1;
    logic [miwf_pkg::VTX_W-1:0] in_v2;
    logic [miwf_pkg::VTX_W-1:0] in_v3;
    logic                      flag_value;

    modport source (output valid, func, in_v0, in_v1, in_v2, in_v3, flag_value,
                    input ready);
    modport sink (input valid, func, in_v0, in_v1, in_v2, in_v3, flag_value,
                  output ready);
endinterface

interface miwf_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [miwf_pkg::VTX_W-1:0] out_v0;
    logic [miwf_pkg::VTX_W-1:0] out_v1;
    logic [miwf_pkg::VTX_W-1:0] out_v2;
    logic [miwf_pkg::VTX_W-1:0] out_v3;
    logic                      last_of_run;

    modport source (output valid, kind, out_v0, out_v1, out_v2, out_v3, last_of_run,
                    input ready);
    modport sink (input valid, kind, out_v0, out_v1, out_v2, out_v3, last_of_run,
                  output ready);
endinterface

// ----- sv/miwf_datapath.sv -----
// Datapath of the mesh interior wire filter: item registers, flag memory,
// flag capture, result mask and the output register.
// Depends on miwf_pkg; driven by miwf_ctrl through t_cmd.
module miwf_datapath #(
    parameter int unsigned MAX_VERTICES = miwf_pkg::MAX_VERTICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    input  logic [1:0]                  i_func,
    input  logic [miwf_pkg::VTX_W-1:0]  i_v0,
    input  logic [miwf_pkg::VTX_W-1:0]  i_v1,
    input  logic [miwf_pkg::VTX_W-1:0]  i_v2,
    input  logic [miwf_pkg::VTX_W-1:0]  i_v3,
    input  logic                        i_flag_value,
    input  miwf_pkg::t_cmd              i_cmd,
    output miwf_pkg::t_status           o_stat,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [1:0]                  o_kind,
    output logic [miwf_pkg::VTX_W-1:0]  o_v0,
    output logic [miwf_pkg::VTX_W-1:0]  o_v1,
    output logic [miwf_pkg::VTX_W-1:0]  o_v2,
    output logic [miwf_pkg::VTX_W-1:0]  o_v3,
    output logic                        o_last
);

    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic                       r_present;
    logic [1:0]                 r_func;
    logic [miwf_pkg::VTX_W-1:0] r_v [4];
    logic                       r_flag_val;
    logic                       r_mem [MAX_VERTICES];
    logic                       r_mem_q;
    logic                       r_rd_ok;
    logic                       r_rd_pend;
    logic [1:0]                 r_rd_slot;
    logic [3:0]                 r_flags;
    logic                       r_out_valid;
    logic [1:0]                 r_kind;
    logic [miwf_pkg::VTX_W-1:0] r_o0, r_o1, r_o2, r_o3;
    logic                       r_last;

    logic [miwf_pkg::VTX_W-1:0] rd_idx;
    logic [miwf_pkg::VTX_W-1:0] wr_idx;
    logic                       rd_in_range;
    logic                       wr_in_range;
    logic [miwf_pkg::N_SLOTS-1:0] mask;
    logic                       is_quad;
    logic [1:0]                 sel_a;
    logic [1:0]                 sel_b;
    logic [3:0]                 b;

    assign rd_idx      = r_v[i_cmd.rd_sel];
    assign wr_idx      = r_v[0];
    assign rd_in_range = 32'(rd_idx) < MAX_VERTICES;
    assign wr_in_range = 32'(wr_idx) < MAX_VERTICES;
    assign is_quad     = (r_func == miwf_pkg::FUNC_QUAD);
    assign b           = r_flags;

    always_comb begin
        mask = '0;
        if (!r_present) begin
            mask[miwf_pkg::SLOT_FACE] = 1'b1;
        end else if (is_quad) begin
            mask[0] = !(b[0] && b[1]);
            mask[1] = !(b[1] && b[2]);
            mask[2] = !(b[2] && b[3]);
            mask[3] = !(b[3] && b[0]);
            mask[4] = &b;
        end else begin
            mask[0] = !(b[0] && b[1]);
            mask[1] = !(b[1] && b[2]);
            mask[2] = !(b[2] && b[0]);
            mask[4] = b[0] && b[1] && b[2];
        end
    end

    assign o_stat.func     = r_func;
    assign o_stat.present  = r_present;
    assign o_stat.mask     = mask;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_present <= i_cfg_wr_data;
            end
            r_rd_pend <= i_cmd.rd_en;
            if (i_cmd.emit_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= i_func;
            r_v[0]     <= i_v0;
            r_v[1]     <= i_v1;
            r_v[2]     <= i_v2;
            r_v[3]     <= (i_func == miwf_pkg::FUNC_TRI) ? '0 : i_v3;
            r_flag_val <= i_flag_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_slot <= i_cmd.rd_sel;
        end
        if (r_rd_pend) begin
            r_flags[r_rd_slot] <= r_mem_q && r_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_in_range) begin
            r_mem[AW'(wr_idx)] <= r_flag_val;
        end
        if (i_cmd.rd_en) begin
            r_mem_q <= r_mem[AW'(rd_idx)];
            r_rd_ok <= rd_in_range;
        end
    end

    always_comb begin
        sel_a = i_cmd.emit_sel[1:0];
        if (i_cmd.emit_sel == 3'd3 || (i_cmd.emit_sel == 3'd2 && !is_quad)) begin
            sel_b = 2'd0;
        end else begin
            sel_b = 2'(i_cmd.emit_sel + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_en) begin
            r_last <= i_cmd.emit_last;
            if (i_cmd.emit_sel == miwf_pkg::SLOT_FACE) begin
                r_kind <= r_func;
                r_o0   <= r_v[0];
                r_o1   <= r_v[1];
                r_o2   <= r_v[2];
                r_o3   <= r_v[3];
            end else begin
                r_kind <= miwf_pkg::KIND_LINE;
                r_o0   <= r_v[sel_a];
                r_o1   <= r_v[sel_b];
                r_o2   <= '0;
                r_o3   <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_v0        = r_o0;
    assign o_v1        = r_o1;
    assign o_v2        = r_o2;
    assign o_v3        = r_o3;
    assign o_last      = r_last;

endmodule

// ----- sv/miwf_ctrl.sv -----
// Controller of the mesh interior wire filter: sequences flag loads, flag
// reads and result emission. Depends on miwf_pkg; drives miwf_datapath.
module miwf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [1:0]        i_func,
    output logic              o_req_ready,
    input  miwf_pkg::t_status i_stat,
    output miwf_pkg::t_cmd    o_cmd
);

    miwf_pkg::t_state             r_state, n_state;
    logic [1:0]                   r_cnt, n_cnt;
    logic [miwf_pkg::N_SLOTS-1:0] r_pend, n_pend;

    logic [2:0]                   low_sel;
    logic [miwf_pkg::N_SLOTS-1:0] low_bit;
    logic [1:0]                   last_cnt;

    always_comb begin
        low_sel = miwf_pkg::SLOT_FACE;
        for (int i = miwf_pkg::N_SLOTS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                low_sel = 3'(i);
            end
        end
        low_bit = miwf_pkg::N_SLOTS'(1) << low_sel;
    end

    assign last_cnt = (i_stat.func == miwf_pkg::FUNC_QUAD) ? 2'd3 : 2'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= miwf_pkg::S_IDLE;
            r_cnt   <= '0;
            r_pend  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            miwf_pkg::S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
                n_cnt         = '0;
                if (i_req_valid) begin
                    case (i_func)
                        miwf_pkg::FUNC_LOAD: n_state = miwf_pkg::S_LOAD;
                        miwf_pkg::FUNC_TRI,
                        miwf_pkg::FUNC_QUAD: n_state = miwf_pkg::S_READ;
                        default:             n_state = miwf_pkg::S_IDLE;
                    endcase
                end
            end
            miwf_pkg::S_LOAD: begin
                o_cmd.wr_en = 1'b1;
                n_state     = miwf_pkg::S_IDLE;
            end
            miwf_pkg::S_READ: begin
                if (!i_stat.present) begin
                    n_state = miwf_pkg::S_PREP;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = r_cnt;
                    n_cnt        = r_cnt + 2'd1;
                    if (r_cnt == last_cnt) begin
                        n_state = miwf_pkg::S_FLUSH;
                    end
                end
            end
            miwf_pkg::S_FLUSH: begin
                n_state = miwf_pkg::S_PREP;
            end
            miwf_pkg::S_PREP: begin
                n_pend  = i_stat.mask;
                n_state = miwf_pkg::S_EMIT;
            end
            miwf_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_en   = 1'b1;
                    o_cmd.emit_sel  = low_sel;
                    o_cmd.emit_last = (r_pend & ~low_bit) == '0;
                    n_pend          = r_pend & ~low_bit;
                    if ((r_pend & ~low_bit) == '0) begin
                        n_state = miwf_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = miwf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/mesh_interior_wire_filter.sv -----
// Top level of the mesh interior wire filter.
// Depends on miwf_pkg, miwf_ifs, miwf_ctrl and miwf_datapath.
//
// Requests arrive on i_req (valid/ready). A load request writes one vertex
// boundary flag; a triangle or quad request produces one to four results on
// o_rsp (valid/ready), the last marked by last_of_run. The single config bit
// i_cfg_wr_data, written when i_cfg_wr_en is high, selects filtering by the
// boundary flags; when it is clear each face passes through as one result.
// One request is handled at a time and i_req.ready is high only while idle.
// A load writes its flag in the load state. A pass-through face goes through
// the read, prep and emit states. A filtered face reads its 3 or 4 flags from
// the flag memory, one per cycle, then passes the flush and prep states and
// emits one result per cycle while the output register is free. The next
// request is taken once the last result has been loaded into the output
// register, so one result may still wait while the next starts.
// When o_rsp.ready is low the output register holds and emission pauses.
// Reset clears the controller, the output valid and the config bit; the flag
// memory is not cleared and a flag must be loaded before it is read.
module mesh_interior_wire_filter #(
    parameter int unsigned MAX_VERTICES = miwf_pkg::MAX_VERTICES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    miwf_req_if.sink        i_req,
    miwf_rsp_if.source      o_rsp
);

    miwf_pkg::t_cmd    cmd;
    miwf_pkg::t_status stat;

    miwf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_func      (i_req.func),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    miwf_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_func        (i_req.func),
        .i_v0          (i_req.in_v0),
        .i_v1          (i_req.in_v1),
        .i_v2          (i_req.in_v2),
        .i_v3          (i_req.in_v3),
        .i_flag_value  (i_req.flag_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_kind        (o_rsp.kind),
        .o_v0          (o_rsp.out_v0),
        .o_v1          (o_rsp.out_v1),
        .o_v2          (o_rsp.out_v2),
        .o_v3          (o_rsp.out_v3),
        .o_last        (o_rsp.last_of_run)
    );

endmodule

// ----- test/tb_mesh_interior_wire_filter.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for mesh_interior_wire_filter, with random stalls on both channels.
// Needs miwf_pkg, the miwf_req_if and miwf_rsp_if interfaces and the block's RTL.
// Faces are predicted from a local copy of the boundary flags and checked in order.
module tb_mesh_interior_wire_filter;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         STALL_LIMIT = 2000;
    localparam int         RANDOM_PER_PHASE = 46;

    typedef struct packed {
        logic [1:0]                 func;
        logic [miwf_pkg::VTX_W-1:0] v0;
        logic [miwf_pkg::VTX_W-1:0] v1;
        logic [miwf_pkg::VTX_W-1:0] v2;
        logic [miwf_pkg::VTX_W-1:0] v3;
        logic                       flag_value;
    } t_vtx_req;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [miwf_pkg::VTX_W-1:0] v0;
        logic [miwf_pkg::VTX_W-1:0] v1;
        logic [miwf_pkg::VTX_W-1:0] v2;
        logic [miwf_pkg::VTX_W-1:0] v3;
        logic                       last;
    } t_prim;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    miwf_req_if req_if ();
    miwf_rsp_if rsp_if ();

    mesh_interior_wire_filter u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    t_vtx_req   pending_reqs [$];
    t_prim      expected_prims [$];
    t_vtx_req   cur_req;
    bit         boundary_flag [0:65535];
    bit         filter_enabled;
    bit         gen_flag [0:65535];
    bit         gen_written [0:65535];
    logic [miwf_pkg::VTX_W-1:0] loaded_vtx [$];
    int         issued_cnt;
    int         accepted_cnt;
    int         fail_count;
    int         send_gap;
    int         take_gap;
    int         quiet_cycles;
    bit         idle_on;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void add_prim(t_prim p);
        expected_prims.insert(expected_prims.size(), p);
    endfunction

    function automatic void predict_prims(t_vtx_req r);
        logic [miwf_pkg::VTX_W-1:0] ring [4];
        bit                         on_b [4];
        int                         n;
        int                         j;
        bit                         all_b;
        if (r.func == miwf_pkg::FUNC_LOAD) begin
            boundary_flag[r.v0] = r.flag_value;
            return;
        end
        if (r.func != miwf_pkg::FUNC_TRI && r.func != miwf_pkg::FUNC_QUAD) return;
        n = (r.func == miwf_pkg::FUNC_TRI) ? 3 : 4;
        ring[0] = r.v0;
        ring[1] = r.v1;
        ring[2] = r.v2;
        ring[3] = (n == 3) ? '0 : r.v3;
        if (!filter_enabled) begin
            add_prim('{r.func, ring[0], ring[1], ring[2], ring[3], 1'b1});
            return;
        end
        all_b = 1'b1;
        for (int i = 0; i < n; i++) begin
            on_b[i] = boundary_flag[ring[i]];
            all_b &= on_b[i];
        end
        for (int i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            if (!on_b[i] || !on_b[j]) begin
                add_prim('{miwf_pkg::KIND_LINE, ring[i], ring[j], '0, '0, 1'b0});
            end
        end
        if (all_b) begin
            add_prim('{r.func, ring[0], ring[1], ring[2], ring[3], 1'b0});
        end
        expected_prims[expected_prims.size() - 1].last = 1'b1;
    endfunction

    function automatic void push_req(logic [1:0] func, logic [miwf_pkg::VTX_W-1:0] v0,
                                     logic [miwf_pkg::VTX_W-1:0] v1,
                                     logic [miwf_pkg::VTX_W-1:0] v2,
                                     logic [miwf_pkg::VTX_W-1:0] v3, logic flag_value);
        if (func == miwf_pkg::FUNC_LOAD) begin
            gen_flag[v0] = flag_value;
            if (!gen_written[v0]) begin
                gen_written[v0] = 1'b1;
                loaded_vtx.insert(loaded_vtx.size(), v0);
            end
        end
        pending_reqs.insert(pending_reqs.size(),
                            t_vtx_req'{func, v0, v1, v2, v3, flag_value});
        issued_cnt++;
    endfunction

    function automatic logic [miwf_pkg::VTX_W-1:0] pick_vertex(bit want_boundary);
        logic [miwf_pkg::VTX_W-1:0] v;
        v = loaded_vtx[$urandom_range(0, loaded_vtx.size() - 1)];
        for (int t = 0; t < 8 && want_boundary && !gen_flag[v]; t++) begin
            v = loaded_vtx[$urandom_range(0, loaded_vtx.size() - 1)];
        end
        return v;
    endfunction

    function automatic void push_random_req(bit filt);
        logic [1:0]                 func;
        logic [miwf_pkg::VTX_W-1:0] v [4];
        int                         sel;
        bit                         want_b;
        for (int i = 0; i < 4; i++) v[i] = 16'($urandom_range(0, 65535));
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            func = miwf_pkg::FUNC_LOAD;
            if ($urandom_range(0, 1) == 1) v[0] = pick_vertex(1'b0);
        end else if (sel < 35) begin
            func = FUNC_UNUSED;
        end else begin
            func = ($urandom_range(0, 1) == 1) ? miwf_pkg::FUNC_QUAD : miwf_pkg::FUNC_TRI;
            if (filt || $urandom_range(0, 1) == 1) begin
                want_b = ($urandom_range(0, 2) == 0);
                v[0] = pick_vertex(want_b);
                v[1] = pick_vertex(want_b);
                v[2] = pick_vertex(want_b);
                if (func == miwf_pkg::FUNC_QUAD) v[3] = pick_vertex(want_b);
            end
        end
        push_req(func, v[0], v[1], v[2], v[3], 1'($urandom_range(0, 1)));
    endfunction

    task automatic drain();
        while (accepted_cnt != issued_cnt || expected_prims.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_filter(bit value);
        drain();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        filter_enabled = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic compare_field(string name, logic [miwf_pkg::VTX_W-1:0] exp_val,
                                 logic [miwf_pkg::VTX_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            req_if.func <= miwf_pkg::FUNC_LOAD;
            req_if.in_v0 <= '0;
            req_if.in_v1 <= '0;
            req_if.in_v2 <= '0;
            req_if.in_v3 <= '0;
            req_if.flag_value <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_prims(cur_req);
                accepted_cnt++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && idle_on
                             && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 15);
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    req_if.func <= cur_req.func;
                    req_if.in_v0 <= cur_req.v0;
                    req_if.in_v1 <= cur_req.v1;
                    req_if.in_v2 <= cur_req.v2;
                    req_if.in_v3 <= cur_req.v3;
                    req_if.flag_value <= cur_req.flag_value;
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        t_prim exp_prim;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_prims.size() == 0) begin
                    $error("unexpected result: kind %0d, v0 %0d, v1 %0d",
                           rsp_if.kind, rsp_if.out_v0, rsp_if.out_v1);
                    fail_count++;
                end else begin
                    exp_prim = expected_prims.pop_front();
                    compare_field("kind", exp_prim.kind, rsp_if.kind);
                    compare_field("out_v0", exp_prim.v0, rsp_if.out_v0);
                    compare_field("out_v1", exp_prim.v1, rsp_if.out_v1);
                    compare_field("out_v2", exp_prim.v2, rsp_if.out_v2);
                    compare_field("out_v3", exp_prim.v3, rsp_if.out_v3);
                    compare_field("last_of_run", exp_prim.last, rsp_if.last_of_run);
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                rsp_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                take_gap = $urandom_range(0, 15);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_mesh_interior_wire_filter: FAIL");
            $finish;
        end
    end

    initial begin
        bit phase_filter [5];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        filter_enabled = 1'b0;
        idle_on = 1'b1;
        phase_filter = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Pass-through: faces come back as they went in, a triangle's fourth vertex as zero.
        set_filter(1'b0);
        push_req(miwf_pkg::FUNC_TRI, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
        push_req(miwf_pkg::FUNC_QUAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        push_req(miwf_pkg::FUNC_TRI, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 1'b1);
        push_req(FUNC_UNUSED, 16'h1234, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
        push_req(miwf_pkg::FUNC_LOAD, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

        // Filtering: all-boundary faces, all-interior faces, mixed faces and a reload.
        set_filter(1'b1);
        push_req(miwf_pkg::FUNC_LOAD, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        push_req(miwf_pkg::FUNC_LOAD, 16'h0001, 16'hAAAA, 16'h5555, 16'hFFFF, 1'b1);
        push_req(miwf_pkg::FUNC_LOAD, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        push_req(miwf_pkg::FUNC_LOAD, 16'h0003, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        push_req(miwf_pkg::FUNC_LOAD, 16'h5555, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        push_req(miwf_pkg::FUNC_LOAD, 16'hAAAA, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        push_req(miwf_pkg::FUNC_TRI, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 1'b0);
        push_req(miwf_pkg::FUNC_TRI, 16'h0002, 16'h0003, 16'hAAAA, 16'h0000, 1'b1);
        push_req(miwf_pkg::FUNC_QUAD, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555, 1'b0);
        push_req(miwf_pkg::FUNC_QUAD, 16'h0002, 16'h0003, 16'hAAAA, 16'h0002, 1'b0);
        push_req(miwf_pkg::FUNC_QUAD, 16'h0000, 16'h0002, 16'h0001, 16'hFFFF, 1'b1);
        push_req(miwf_pkg::FUNC_TRI, 16'h0000, 16'h0000, 16'h0002, 16'hFFFF, 1'b0);
        push_req(FUNC_UNUSED, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 1'b0);
        push_req(miwf_pkg::FUNC_LOAD, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        push_req(miwf_pkg::FUNC_TRI, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000, 1'b0);
        push_req(miwf_pkg::FUNC_TRI, 16'h5555, 16'h5555, 16'h5555, 16'hFFFF, 1'b1);

        for (int p = 0; p < 5; p++) begin
            set_filter(phase_filter[p]);
            if (p == 4) idle_on = 1'b0;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) push_random_req(phase_filter[p]);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_prims.size() != 0) begin
            $error("%0d expected results never arrived", expected_prims.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb_mesh_interior_wire_filter: PASS");
        end else begin
            $display("tb_mesh_interior_wire_filter: FAIL");
        end
        $finish;
    end
endmodule
